[rtl/aat_pkg.sv]
`timescale 1ns / 1ps

package aat_pkg;

	// batch and angle settings
	localparam int MaxSamples = 16;
	localparam int AngleIters = 16;

	// field and datapath widths
	localparam int SmpW    = 16;
	localparam int CntW    = 5;
	localparam int SumW    = 21;
	localparam int MagW    = 20;
	localparam int DremW   = 5;
	localparam int AvgW    = 17;
	localparam int FacW    = 10;
	localparam int UgW     = 26;
	localparam int SqW     = 32;
	localparam int RadW    = 64;
	localparam int RootW   = 32;
	localparam int SremW   = 36;
	localparam int CorW    = 35;
	localparam int ZW      = 25;
	localparam int TabW    = 22;
	localparam int AngW    = 16;
	localparam int StepW   = 5;
	localparam int CfgIdxW = 1;
	localparam int CfgW    = 3;

	// sequencer step counts
	localparam int DivSteps  = MagW;
	localparam int SqrtSteps = RootW;

	// angle limit in 1/256 degree
	localparam int AngleLimit = 23040;

	// register indexes
	localparam logic [CfgIdxW-1:0] CfgAveraging = 1'b0;
	localparam logic [CfgIdxW-1:0] CfgRange     = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_SUM,
		S_SQRT,
		S_CINIT,
		S_CORDIC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             take;
		logic             div_step;
		logic             mul;
		logic             sum;
		logic             sqrt_step;
		logic             cinit;
		logic             cordic_step;
		logic             load;
		logic [StepW-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic smp_valid;
		logic smp_last;
		logic out_free;
	} stat_t;

	// atan(2^-i) in degrees, Q.16
	function automatic logic [TabW-1:0] atan_entry(input logic [StepW-1:0] i);
		logic [TabW-1:0] v;
		unique case (i)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			5'd21:   v = 22'd2;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

	// micro-g per lsb by full-scale code
	function automatic logic [FacW-1:0] ug_factor(input logic [CfgW-1:0] r);
		logic [FacW-1:0] v;
		unique case (r)
			3'd0:    v = 10'd61;
			3'd1:    v = 10'd122;
			3'd2:    v = 10'd183;
			3'd3:    v = 10'd244;
			3'd4:    v = 10'd732;
			default: v = 10'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/aat_if.sv]
`timescale 1ns / 1ps

// sample channel
interface aat_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [aat_pkg::SmpW-1:0]      sample_x;
	logic signed [aat_pkg::SmpW-1:0]      sample_y;
	logic signed [aat_pkg::SmpW-1:0]      sample_z;
	logic                                 last_sample;

	modport source(output valid, sample_x, sample_y, sample_z, last_sample, input ready);
	modport sink(input valid, sample_x, sample_y, sample_z, last_sample, output ready);
endinterface

// result channel
interface aat_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [aat_pkg::UgW-1:0]       accel_x_ug;
	logic signed [aat_pkg::UgW-1:0]       accel_y_ug;
	logic signed [aat_pkg::UgW-1:0]       accel_z_ug;
	logic signed [aat_pkg::AngW-1:0]      pitch_angle;
	logic signed [aat_pkg::AngW-1:0]      roll_angle;
	logic [aat_pkg::CntW-1:0]             samples_used;
	logic                                 batch_overflow;

	modport source(output valid, accel_x_ug, accel_y_ug, accel_z_ug, pitch_angle,
		roll_angle, samples_used, batch_overflow, input ready);
	modport sink(input valid, accel_x_ug, accel_y_ug, accel_z_ug, pitch_angle,
		roll_angle, samples_used, batch_overflow, output ready);
endinterface

[rtl/aat_ctrl.sv]
`timescale 1ns / 1ps

module aat_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  aat_pkg::stat_t st,
	output aat_pkg::cmd_t  cmd
);

	aat_pkg::state_t                state_q, state_d;
	logic [aat_pkg::StepW-1:0]      cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aat_pkg::S_IDLE: begin
				if (st.smp_valid && st.smp_last) state_d = aat_pkg::S_DIV;
			end
			aat_pkg::S_DIV: begin
				if (cnt_q == aat_pkg::StepW'(aat_pkg::DivSteps - 1)) state_d = aat_pkg::S_MUL;
			end
			aat_pkg::S_MUL:   state_d = aat_pkg::S_SUM;
			aat_pkg::S_SUM:   state_d = aat_pkg::S_SQRT;
			aat_pkg::S_SQRT: begin
				if (cnt_q == aat_pkg::StepW'(aat_pkg::SqrtSteps - 1)) state_d = aat_pkg::S_CINIT;
			end
			aat_pkg::S_CINIT: state_d = aat_pkg::S_CORDIC;
			aat_pkg::S_CORDIC: begin
				if (cnt_q == aat_pkg::StepW'(aat_pkg::AngleIters - 1)) state_d = aat_pkg::S_DONE;
			end
			aat_pkg::S_DONE: begin
				if (st.out_free) state_d = aat_pkg::S_IDLE;
			end
			default: state_d = aat_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd             = '0;
		cmd.step        = cnt_q;
		cmd.take        = (state_q == aat_pkg::S_IDLE);
		cmd.div_step    = (state_q == aat_pkg::S_DIV);
		cmd.mul         = (state_q == aat_pkg::S_MUL);
		cmd.sum         = (state_q == aat_pkg::S_SUM);
		cmd.sqrt_step   = (state_q == aat_pkg::S_SQRT);
		cmd.cinit       = (state_q == aat_pkg::S_CINIT);
		cmd.cordic_step = (state_q == aat_pkg::S_CORDIC);
		cmd.load        = (state_q == aat_pkg::S_DONE) && st.out_free;
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aat_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

[rtl/aat_datapath.sv]
`timescale 1ns / 1ps

module aat_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aat_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [aat_pkg::CfgW-1:0]      cfg_data,
	aat_sample_if.sink                    samples,
	aat_result_if.source                  results,
	input  aat_pkg::cmd_t                 cmd,
	output aat_pkg::stat_t                st
);

	localparam int SumW  = aat_pkg::SumW;
	localparam int MagW  = aat_pkg::MagW;
	localparam int AvgW  = aat_pkg::AvgW;
	localparam int CorW  = aat_pkg::CorW;
	localparam int ZW    = aat_pkg::ZW;
	localparam int SremW = aat_pkg::SremW;
	localparam int RootW = aat_pkg::RootW;
	localparam int RadW  = aat_pkg::RadW;
	localparam int SqW   = aat_pkg::SqW;
	localparam int CntW  = aat_pkg::CntW;

	// configuration
	logic                        avg_on_q;
	logic [aat_pkg::CfgW-1:0]    range_q;

	// accumulators
	logic signed [SumW-1:0]      sum_q [3];
	logic signed [SumW-1:0]      nsum  [3];
	logic signed [SumW-1:0]      smp   [3];
	logic [CntW-1:0]             cnt_q, ncnt;
	logic                        drop_q, ndrop, full, last_eff, take;

	// divider lanes
	logic [MagW-1:0]             mag_q  [3];
	logic [aat_pkg::DremW-1:0]   drem_q [3];
	logic                        neg_q  [3];
	logic [CntW-1:0]             div_n_q, used_q;
	logic                        ovf_q;
	logic [MagW-1:0]             mag_d  [3];
	logic [aat_pkg::DremW-1:0]   drem_d [3];

	// scaled values and squares
	logic signed [AvgW-1:0]      avg    [3];
	logic signed [AvgW-1:0]      avg_q  [3];
	logic signed [aat_pkg::UgW-1:0] ug_q [3];
	logic [SqW-1:0]              sqv_q  [3];
	logic signed [AvgW+aat_pkg::FacW:0] prod [3];
	logic signed [2*AvgW-1:0]    sqp    [3];

	// angle lanes: 0 pitch, 1 roll
	logic [SqW-1:0]              sq_q   [2];
	logic [RadW-1:0]             rad_q  [2];
	logic [RootW-1:0]            root_q [2];
	logic [SremW-1:0]            srem_q [2];
	logic signed [CorW-1:0]      px_q   [2];
	logic signed [CorW-1:0]      py_q   [2];
	logic signed [ZW-1:0]        z_q    [2];
	logic signed [AvgW-1:0]      num    [2];
	logic signed [aat_pkg::AngW-1:0] ang [2];

	// sample intake
	assign full     = (cnt_q == CntW'(aat_pkg::MaxSamples));
	assign last_eff = samples.last_sample | ~avg_on_q;
	assign take     = cmd.take && samples.valid;
	assign ncnt     = full ? cnt_q : cnt_q + 1'b1;
	assign ndrop    = drop_q | full;
	assign smp[0]   = SumW'(samples.sample_x);
	assign smp[1]   = SumW'(samples.sample_y);
	assign smp[2]   = SumW'(samples.sample_z);
	assign samples.ready = cmd.take;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nsum[k] = full ? sum_q[k] : sum_q[k] + smp[k];
		end
	end

	// status
	assign st.smp_valid = samples.valid;
	assign st.smp_last  = last_eff;
	assign st.out_free  = ~results.valid | results.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_on_q <= 1'b1;
			range_q  <= 3'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aat_pkg::CfgAveraging: avg_on_q <= cfg_data[0];
				aat_pkg::CfgRange:     range_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// batch accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) sum_q[k] <= '0;
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (take) begin
			if (last_eff) begin
				for (int k = 0; k < 3; k++) sum_q[k] <= '0;
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end else begin
				for (int k = 0; k < 3; k++) sum_q[k] <= nsum[k];
				cnt_q  <= ncnt;
				drop_q <= ndrop;
			end
		end
	end

	// restoring divide step, one quotient bit per cycle
	always_comb begin
		logic [aat_pkg::DremW:0] trial;
		for (int k = 0; k < 3; k++) begin
			trial = {drem_q[k], mag_q[k][MagW-1]};
			if (trial >= {1'b0, div_n_q}) begin
				drem_d[k] = aat_pkg::DremW'(trial - {1'b0, div_n_q});
				mag_d[k]  = {mag_q[k][MagW-2:0], 1'b1};
			end else begin
				drem_d[k] = trial[aat_pkg::DremW-1:0];
				mag_d[k]  = {mag_q[k][MagW-2:0], 1'b0};
			end
		end
	end

	// signed averages, scaling and squares
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			avg[k]  = neg_q[k] ? -$signed(AvgW'(mag_q[k])) : $signed(AvgW'(mag_q[k]));
			prod[k] = avg[k] * $signed({1'b0, aat_pkg::ug_factor(range_q)});
			sqp[k]  = avg[k] * avg[k];
		end
	end

	assign num[0] = avg_q[0];
	assign num[1] = avg_q[1];

	// angle rounding, clamp and special cases
	always_comb begin
		logic signed [ZW-1:0]   zr;
		logic signed [ZW-9:0]   r;
		for (int j = 0; j < 2; j++) begin
			zr = z_q[j] + ZW'(128);
			r  = zr[ZW-1:8];
			if (r > (ZW-8)'(aat_pkg::AngleLimit)) r = (ZW-8)'(aat_pkg::AngleLimit);
			if (r < -(ZW-8)'(aat_pkg::AngleLimit)) r = -(ZW-8)'(aat_pkg::AngleLimit);
			if (num[j] == '0) ang[j] = '0;
			else if (sq_q[j] == '0)
				ang[j] = num[j][AvgW-1] ? -aat_pkg::AngW'(aat_pkg::AngleLimit)
					: aat_pkg::AngW'(aat_pkg::AngleLimit);
			else ang[j] = r[aat_pkg::AngW-1:0];
		end
	end

	// arithmetic sequence registers
	always_ff @(posedge clk) begin
		logic [SremW-1:0]       t, trial;
		logic signed [CorW-1:0] dx, dy;
		// batch close: load dividends
		if (take && last_eff) begin
			for (int k = 0; k < 3; k++) begin
				mag_q[k]  <= nsum[k][SumW-1] ? MagW'(-nsum[k]) : MagW'(nsum[k]);
				neg_q[k]  <= nsum[k][SumW-1];
				drem_q[k] <= '0;
			end
			div_n_q <= (ncnt == '0) ? CntW'(1) : ncnt;
			used_q  <= ncnt;
			ovf_q   <= ndrop;
		end
		if (cmd.div_step) begin
			for (int k = 0; k < 3; k++) begin
				mag_q[k]  <= mag_d[k];
				drem_q[k] <= drem_d[k];
			end
		end
		if (cmd.mul) begin
			for (int k = 0; k < 3; k++) begin
				avg_q[k] <= avg[k];
				ug_q[k]  <= prod[k][aat_pkg::UgW-1:0];
				sqv_q[k] <= SqW'(sqp[k]);
			end
		end
		// magnitude squares and root set-up
		if (cmd.sum) begin
			sq_q[0]  <= sqv_q[1] + sqv_q[2];
			sq_q[1]  <= sqv_q[0] + sqv_q[2];
			rad_q[0] <= {sqv_q[1] + sqv_q[2], 32'b0};
			rad_q[1] <= {sqv_q[0] + sqv_q[2], 32'b0};
			for (int j = 0; j < 2; j++) begin
				root_q[j] <= '0;
				srem_q[j] <= '0;
			end
		end
		// square root, one result bit per cycle
		if (cmd.sqrt_step) begin
			for (int j = 0; j < 2; j++) begin
				t     = {srem_q[j][SremW-3:0], rad_q[j][RadW-1:RadW-2]};
				trial = SremW'({root_q[j], 2'b01});
				if (t >= trial) begin
					srem_q[j] <= t - trial;
					root_q[j] <= {root_q[j][RootW-2:0], 1'b1};
				end else begin
					srem_q[j] <= t;
					root_q[j] <= {root_q[j][RootW-2:0], 1'b0};
				end
				rad_q[j] <= {rad_q[j][RadW-3:0], 2'b00};
			end
		end
		// vectoring set-up
		if (cmd.cinit) begin
			for (int j = 0; j < 2; j++) begin
				px_q[j] <= $signed(CorW'(root_q[j]));
				py_q[j] <= $signed(CorW'(num[j])) <<< 16;
				z_q[j]  <= '0;
			end
		end
		// vectoring iteration
		if (cmd.cordic_step) begin
			for (int j = 0; j < 2; j++) begin
				dx = py_q[j] >>> cmd.step;
				dy = px_q[j] >>> cmd.step;
				if (py_q[j] > 0) begin
					px_q[j] <= px_q[j] + dx;
					py_q[j] <= py_q[j] - dy;
					z_q[j]  <= z_q[j] + $signed(ZW'(aat_pkg::atan_entry(cmd.step)));
				end else begin
					px_q[j] <= px_q[j] - dx;
					py_q[j] <= py_q[j] + dy;
					z_q[j]  <= z_q[j] - $signed(ZW'(aat_pkg::atan_entry(cmd.step)));
				end
			end
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) results.valid <= 1'b0;
		else if (cmd.load) results.valid <= 1'b1;
		else if (results.ready) results.valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			results.accel_x_ug     <= ug_q[0];
			results.accel_y_ug     <= ug_q[1];
			results.accel_z_ug     <= ug_q[2];
			results.pitch_angle    <= ang[0];
			results.roll_angle     <= ang[1];
			results.samples_used   <= used_q;
			results.batch_overflow <= ovf_q;
		end
	end

endmodule

[rtl/accel_average_and_tilt.sv]
`timescale 1ns / 1ps

// Accelerometer averaging with pitch and roll.
// samples: one X/Y/Z word per handshake (valid and ready). Words are summed
// until one marked last_sample arrives, or every word ends a batch when
// averaging is off. At most 16 words are summed; later ones are dropped and
// batch_overflow is set in the result.
// results: one word per batch: averages in micro-g, pitch and roll in 1/256
// degree, the sample count and the overflow flag.
// cfg: write enable, index (0 averaging on, 1 full-scale code) and data;
// write only while idle.
// Sequence: samples.ready is high only in idle, where a word that does not end
// a batch is taken at once. A closing word starts the arithmetic (20 divide
// steps, multiply, add, 32 square-root steps, set-up, 16 vectoring steps,
// load), with samples.ready low; the result is valid from the cycle after load.
// The result sits in an output register: a stalled receiver holds it while
// new words are summed, and only a second finished batch waits for it.
// Reset: sums, count and flag clear; averaging on, full-scale code 8g.
module accel_average_and_tilt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aat_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [aat_pkg::CfgW-1:0]      cfg_data,
	aat_sample_if.sink                    samples,
	aat_result_if.source                  results
);

	aat_pkg::cmd_t  cmd;
	aat_pkg::stat_t st;

	aat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	aat_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples),
		.results   (results),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
